### rtl/ofr_pkg.sv
`timescale 1ns / 1ps
// shared types, widths and constants for the orthonormal frame block
// no dependencies

package ofr_pkg;

   localparam int IN_BITS   = 16;
   localparam int FRAC_BITS = 14;
   localparam int OUT_BITS  = 16;
   localparam int NAXIS     = 3;
   localparam int NLANE     = 9;

   // intermediate widths, all follow from the input width
   localparam int P_W   = 2 * IN_BITS;
   localparam int C_W   = 2 * IN_BITS + 1;
   localparam int ASQ_W = 2 * IN_BITS;
   localparam int CM_W  = 2 * IN_BITS;
   localparam int CSQ_W = 4 * IN_BITS;
   localparam int WM_W  = 3 * IN_BITS;
   localparam int WL_W  = (WM_W + 1) / 2;
   localparam int WH_W  = WM_W - WL_W;
   localparam int DEN_W = 6 * IN_BITS;

   // residual width of the square root cells
   localparam int RW   = 6 * IN_BITS + 2 * FRAC_BITS + 5;
   localparam int Q_W  = FRAC_BITS + 1;
   localparam int OX_W = (FRAC_BITS + 2 > OUT_BITS) ? FRAC_BITS + 2 : OUT_BITS;

   typedef struct packed {
      logic signed [IN_BITS-1:0] axis_a_x;
      logic signed [IN_BITS-1:0] axis_a_y;
      logic signed [IN_BITS-1:0] axis_a_z;
      logic signed [IN_BITS-1:0] axis_b_x;
      logic signed [IN_BITS-1:0] axis_b_y;
      logic signed [IN_BITS-1:0] axis_b_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] m_r0_c0;
      logic signed [OUT_BITS-1:0] m_r0_c1;
      logic signed [OUT_BITS-1:0] m_r0_c2;
      logic signed [OUT_BITS-1:0] m_r1_c0;
      logic signed [OUT_BITS-1:0] m_r1_c1;
      logic signed [OUT_BITS-1:0] m_r1_c2;
      logic signed [OUT_BITS-1:0] m_r2_c0;
      logic signed [OUT_BITS-1:0] m_r2_c1;
      logic signed [OUT_BITS-1:0] m_r2_c2;
      logic                       degenerate;
   } rsp_type;

   // one matrix entry in flight: residual, running cross term, scaled divisor
   typedef struct packed {
      logic                  neg;
      logic [Q_W-1:0]        q;
      logic signed [RW-1:0]  r;
      logic signed [RW-1:0]  a;
      logic signed [RW-1:0]  b;
   } lane_type;

   typedef struct packed {
      logic                        degenerate;
      lane_type [NLANE-1:0]        lane;
   } frame_type;

endpackage

### rtl/ofr_front.sv
`timescale 1ns / 1ps
// front pipeline: cross product, squared lengths, gram-schmidt remainder and
// setup of the nine square root lanes; uses ofr_pkg

module ofr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  ofr_pkg::req_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output ofr_pkg::frame_type out_data
);
   import ofr_pkg::*;

   localparam int NSTG = 8;

   logic [NSTG-1:0] vld_ff, vld_in, ld;

   logic signed [IN_BITS-1:0] ra [NAXIS];
   logic signed [IN_BITS-1:0] rb [NAXIS];

   // stage 1
   logic signed [IN_BITS-1:0] a1_ff [NAXIS];
   logic signed [P_W-1:0]     pp1_ff [NAXIS], pp1_in [NAXIS];
   logic signed [P_W-1:0]     pn1_ff [NAXIS], pn1_in [NAXIS];
   logic [ASQ_W-1:0]          aa1_ff [NAXIS], aa1_in [NAXIS];
   // stage 2
   logic signed [IN_BITS-1:0] a2_ff [NAXIS];
   logic signed [C_W-1:0]     c2_ff [NAXIS], c2_in [NAXIS];
   logic [ASQ_W-1:0]          aa2_ff [NAXIS];
   logic [ASQ_W-1:0]          asq2_ff, asq2_in;
   // stage 3
   logic [IN_BITS-1:0]        am3_ff [NAXIS], am3_in [NAXIS];
   logic [CM_W-1:0]           cm3_ff [NAXIS], cm3_in [NAXIS];
   logic [NAXIS-1:0]          an3_ff, cn3_ff;
   logic [ASQ_W-1:0]          aa3_ff [NAXIS];
   logic [ASQ_W-1:0]          asq3_ff;
   logic                      dg3_ff, dg3_in;
   // stage 4
   logic [CSQ_W-1:0]          cc4_ff [NAXIS], cc4_in [NAXIS];
   logic [WM_W-1:0]           p14_ff [NAXIS], p14_in [NAXIS];
   logic [WM_W-1:0]           p24_ff [NAXIS], p24_in [NAXIS];
   logic [NAXIS-1:0]          an4_ff, cn4_ff;
   logic [ASQ_W-1:0]          aa4_ff [NAXIS];
   logic [ASQ_W-1:0]          asq4_ff;
   logic                      dg4_ff;
   // stage 5
   logic [WM_W-1:0]           wm5_ff [NAXIS], wm5_in [NAXIS];
   logic [NAXIS-1:0]          wn5_ff, wn5_in;
   logic [CSQ_W-1:0]          csq5_ff, csq5_in;
   logic [CSQ_W-1:0]          cc5_ff [NAXIS];
   logic [NAXIS-1:0]          an5_ff, cn5_ff;
   logic [ASQ_W-1:0]          aa5_ff [NAXIS];
   logic [ASQ_W-1:0]          asq5_ff;
   logic                      dg5_ff;
   // stage 6
   logic [CSQ_W-1:0]          dl6_ff, dl6_in, dh6_ff, dh6_in;
   logic [2*WH_W-1:0]         hh6_ff [NAXIS], hh6_in [NAXIS];
   logic [WH_W+WL_W-1:0]      hl6_ff [NAXIS], hl6_in [NAXIS];
   logic [2*WL_W-1:0]         ll6_ff [NAXIS], ll6_in [NAXIS];
   logic [NAXIS-1:0]          wn6_ff, an6_ff, cn6_ff;
   logic [CSQ_W-1:0]          csq6_ff;
   logic [CSQ_W-1:0]          cc6_ff [NAXIS];
   logic [ASQ_W-1:0]          aa6_ff [NAXIS];
   logic [ASQ_W-1:0]          asq6_ff;
   logic                      dg6_ff;
   // stage 7
   logic [DEN_W-1:0]          den7_ff, den7_in;
   logic [DEN_W-1:0]          wsq7_ff [NAXIS], wsq7_in [NAXIS];
   logic [NAXIS-1:0]          wn7_ff, an7_ff, cn7_ff;
   logic [CSQ_W-1:0]          csq7_ff;
   logic [CSQ_W-1:0]          cc7_ff [NAXIS];
   logic [ASQ_W-1:0]          aa7_ff [NAXIS];
   logic [ASQ_W-1:0]          asq7_ff;
   logic                      dg7_ff;
   // stage 8
   frame_type                 fr8_ff, fr8_in;

   assign ra[0] = in_data.axis_a_x;
   assign ra[1] = in_data.axis_a_y;
   assign ra[2] = in_data.axis_a_z;
   assign rb[0] = in_data.axis_b_x;
   assign rb[1] = in_data.axis_b_y;
   assign rb[2] = in_data.axis_b_z;

   // a stage takes a new word when it is empty or its word moves on
   always_comb begin
      ld[NSTG-1] = ~vld_ff[NSTG-1] | out_ready;
      for (int s = NSTG - 2; s >= 0; s--) begin
         ld[s] = ~vld_ff[s] | ld[s+1];
      end
      vld_in[0] = ld[0] ? in_valid : vld_ff[0];
      for (int s = 1; s < NSTG; s++) begin
         vld_in[s] = ld[s] ? vld_ff[s-1] : vld_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign in_ready  = ld[0];
   assign out_valid = vld_ff[NSTG-1];
   assign out_data  = fr8_ff;

   for (genvar i = 0; i < NAXIS; i++) begin : g_axis
      localparam int J = (i + 1) % NAXIS;
      localparam int K = (i + 2) % NAXIS;
      logic n1, n2, ge;
      logic [WL_W-1:0] wlo;
      logic [WH_W-1:0] whi;

      assign pp1_in[i] = P_W'(ra[J]) * P_W'(rb[K]);
      assign pn1_in[i] = P_W'(ra[K]) * P_W'(rb[J]);
      assign aa1_in[i] = ASQ_W'(P_W'(ra[i]) * P_W'(ra[i]));

      assign c2_in[i] = C_W'(pp1_ff[i]) - C_W'(pn1_ff[i]);

      assign am3_in[i] = a2_ff[i][IN_BITS-1] ? IN_BITS'(-a2_ff[i]) : IN_BITS'(a2_ff[i]);
      assign cm3_in[i] = c2_ff[i][C_W-1] ? CM_W'(-c2_ff[i]) : CM_W'(c2_ff[i]);

      assign cc4_in[i] = CSQ_W'(cm3_ff[i]) * CSQ_W'(cm3_ff[i]);
      assign p14_in[i] = WM_W'(cm3_ff[J]) * WM_W'(am3_ff[K]);
      assign p24_in[i] = WM_W'(cm3_ff[K]) * WM_W'(am3_ff[J]);

      // w = c x a, kept as sign and magnitude
      assign n1 = cn4_ff[J] ^ an4_ff[K];
      assign n2 = ~(cn4_ff[K] ^ an4_ff[J]);
      assign ge = p14_ff[i] >= p24_ff[i];
      always_comb begin
         priority if (n1 == n2) begin
            wm5_in[i] = p14_ff[i] + p24_ff[i];
            wn5_in[i] = n1;
         end else if (ge) begin
            wm5_in[i] = p14_ff[i] - p24_ff[i];
            wn5_in[i] = n1;
         end else begin
            wm5_in[i] = p24_ff[i] - p14_ff[i];
            wn5_in[i] = n2;
         end
      end

      assign wlo = wm5_ff[i][WL_W-1:0];
      assign whi = wm5_ff[i][WM_W-1:WL_W];
      assign hh6_in[i] = (2*WH_W)'(whi) * (2*WH_W)'(whi);
      assign hl6_in[i] = (WH_W+WL_W)'(whi) * (WH_W+WL_W)'(wlo);
      assign ll6_in[i] = (2*WL_W)'(wlo) * (2*WL_W)'(wlo);

      assign wsq7_in[i] = (DEN_W'(hh6_ff[i]) << (2 * WL_W))
                        + (DEN_W'(hl6_ff[i]) << (WL_W + 1))
                        + DEN_W'(ll6_ff[i]);
   end

   assign asq2_in = aa1_ff[0] + aa1_ff[1] + aa1_ff[2];
   assign dg3_in  = (asq2_ff == '0)
                  || (c2_ff[0] == '0 && c2_ff[1] == '0 && c2_ff[2] == '0);
   assign csq5_in = cc4_ff[0] + cc4_ff[1] + cc4_ff[2];
   assign dl6_in  = CSQ_W'(csq5_ff[CSQ_W/2-1:0]) * CSQ_W'(asq5_ff);
   assign dh6_in  = CSQ_W'(csq5_ff[CSQ_W-1:CSQ_W/2]) * CSQ_W'(asq5_ff);
   assign den7_in = (DEN_W'(dh6_ff) << (CSQ_W / 2)) + DEN_W'(dl6_ff);

   // lane setup: residual 4*num*2^(2f) - den, cross term -den*2^(f+2)
   always_comb begin
      logic [DEN_W-1:0] num, den;
      logic             neg;
      fr8_in.degenerate = dg7_ff;
      for (int e = 0; e < NLANE; e++) begin
         num = '0;
         den = '0;
         neg = 1'b0;
         unique case (e % NAXIS)
            0: begin
               num = DEN_W'(aa7_ff[e / NAXIS]);
               den = DEN_W'(asq7_ff);
               neg = an7_ff[e / NAXIS];
            end
            1: begin
               num = wsq7_ff[e / NAXIS];
               den = den7_ff;
               neg = wn7_ff[e / NAXIS];
            end
            default: begin
               num = DEN_W'(cc7_ff[e / NAXIS]);
               den = DEN_W'(csq7_ff);
               neg = cn7_ff[e / NAXIS];
            end
         endcase
         fr8_in.lane[e].neg = neg;
         fr8_in.lane[e].q   = '0;
         fr8_in.lane[e].r   = (RW'(num) << (2 * FRAC_BITS + 2)) - RW'(den);
         fr8_in.lane[e].a   = -(RW'(den) << (FRAC_BITS + 2));
         fr8_in.lane[e].b   = RW'(den) << (2 * FRAC_BITS + 2);
      end
   end

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         for (int i = 0; i < NAXIS; i++) begin
            a1_ff[i]  <= ra[i];
            pp1_ff[i] <= pp1_in[i];
            pn1_ff[i] <= pn1_in[i];
            aa1_ff[i] <= aa1_in[i];
         end
      end
      if (ld[1]) begin
         for (int i = 0; i < NAXIS; i++) begin
            a2_ff[i]  <= a1_ff[i];
            c2_ff[i]  <= c2_in[i];
            aa2_ff[i] <= aa1_ff[i];
         end
         asq2_ff <= asq2_in;
      end
      if (ld[2]) begin
         for (int i = 0; i < NAXIS; i++) begin
            am3_ff[i] <= am3_in[i];
            cm3_ff[i] <= cm3_in[i];
            an3_ff[i] <= a2_ff[i][IN_BITS-1];
            cn3_ff[i] <= c2_ff[i][C_W-1];
            aa3_ff[i] <= aa2_ff[i];
         end
         asq3_ff <= asq2_ff;
         dg3_ff  <= dg3_in;
      end
      if (ld[3]) begin
         for (int i = 0; i < NAXIS; i++) begin
            cc4_ff[i] <= cc4_in[i];
            p14_ff[i] <= p14_in[i];
            p24_ff[i] <= p24_in[i];
            aa4_ff[i] <= aa3_ff[i];
         end
         an4_ff  <= an3_ff;
         cn4_ff  <= cn3_ff;
         asq4_ff <= asq3_ff;
         dg4_ff  <= dg3_ff;
      end
      if (ld[4]) begin
         for (int i = 0; i < NAXIS; i++) begin
            wm5_ff[i] <= wm5_in[i];
            cc5_ff[i] <= cc4_ff[i];
            aa5_ff[i] <= aa4_ff[i];
         end
         wn5_ff  <= wn5_in;
         csq5_ff <= csq5_in;
         an5_ff  <= an4_ff;
         cn5_ff  <= cn4_ff;
         asq5_ff <= asq4_ff;
         dg5_ff  <= dg4_ff;
      end
      if (ld[5]) begin
         for (int i = 0; i < NAXIS; i++) begin
            hh6_ff[i] <= hh6_in[i];
            hl6_ff[i] <= hl6_in[i];
            ll6_ff[i] <= ll6_in[i];
            cc6_ff[i] <= cc5_ff[i];
            aa6_ff[i] <= aa5_ff[i];
         end
         dl6_ff  <= dl6_in;
         dh6_ff  <= dh6_in;
         wn6_ff  <= wn5_ff;
         an6_ff  <= an5_ff;
         cn6_ff  <= cn5_ff;
         csq6_ff <= csq5_ff;
         asq6_ff <= asq5_ff;
         dg6_ff  <= dg5_ff;
      end
      if (ld[6]) begin
         for (int i = 0; i < NAXIS; i++) begin
            wsq7_ff[i] <= wsq7_in[i];
            cc7_ff[i]  <= cc6_ff[i];
            aa7_ff[i]  <= aa6_ff[i];
         end
         den7_ff <= den7_in;
         wn7_ff  <= wn6_ff;
         an7_ff  <= an6_ff;
         cn7_ff  <= cn6_ff;
         csq7_ff <= csq6_ff;
         asq7_ff <= asq6_ff;
         dg7_ff  <= dg6_ff;
      end
      if (ld[7]) begin
         fr8_ff <= fr8_in;
      end
   end

endmodule

### rtl/ofr_cell.sv
`timescale 1ns / 1ps
// one square root cell: settles one result bit of all nine lanes and
// hands the word to the next cell; uses ofr_pkg

module ofr_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  ofr_pkg::frame_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output ofr_pkg::frame_type out_data
);
   import ofr_pkg::*;

   logic      valid_ff;
   frame_type data_ff, data_in;
   lane_type  lane_in [NLANE];

   for (genvar l = 0; l < NLANE; l++) begin : g_lane
      logic signed [RW-1:0] trial;
      logic                 take;

      assign trial = $signed(in_data.lane[l].r) - $signed(in_data.lane[l].a)
                   - $signed(in_data.lane[l].b);
      assign take  = ~trial[RW-1];

      // try the next bit of q: keep it when (2q-1)^2 den still fits
      always_comb begin
         lane_in[l].neg = in_data.lane[l].neg;
         lane_in[l].q   = {in_data.lane[l].q[Q_W-2:0], take};
         lane_in[l].r   = take ? trial : in_data.lane[l].r;
         lane_in[l].a   = ($signed(in_data.lane[l].a) >>> 1)
                        + (take ? $signed(in_data.lane[l].b) : $signed(RW'(0)));
         lane_in[l].b   = in_data.lane[l].b >> 2;
      end
   end

   always_comb begin
      data_in.degenerate = in_data.degenerate;
      for (int l = 0; l < NLANE; l++) begin
         data_in.lane[l] = lane_in[l];
      end
   end

   assign in_ready  = ~valid_ff | out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### rtl/orthonormal_frame_from_two_vectors.sv
`timescale 1ns / 1ps
// top level: front pipeline, chain of square root cells, output register
// uses ofr_pkg, ofr_front, ofr_cell
//
//   channel | ports                          | word
//   --------+--------------------------------+----------------------------
//   input   | req_valid, req_stall, req_data | two signed 3d vectors
//   result  | rsp_valid, rsp_stall, rsp_data | 3x3 matrix in q1.14, flag
//
// one word in and one out per cycle while rsp_stall is low; the path is 8 front stages,
// 15 cells (one per result bit), one output register.
// reset clears only the stage valid bits.
// a stalled output holds its word; stages behind it keep filling until
// they are full, then req_stall rises.

module orthonormal_frame_from_two_vectors (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ofr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ofr_pkg::rsp_type rsp_data
);
   import ofr_pkg::*;

   localparam int NCELL = Q_W;

   frame_type chain_data  [NCELL+1];
   logic      chain_valid [NCELL+1];
   logic      chain_ready [NCELL+1];
   logic      front_ready;

   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff, rsp_data_in;
   logic      out_ld;

   function automatic logic [OUT_BITS-1:0] to_entry(lane_type ln, logic dg);
      logic signed [OX_W-1:0] qx;
      logic signed [OX_W-1:0] sv;
      begin
         qx = OX_W'(ln.q);
         sv = ln.neg ? -qx : qx;
         return dg ? '0 : sv[OUT_BITS-1:0];
      end
   endfunction

   ofr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_data   (req_data),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   for (genvar n = 0; n < NCELL; n++) begin : g_cell
      ofr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[n]),
         .in_ready  (chain_ready[n]),
         .in_data   (chain_data[n]),
         .out_valid (chain_valid[n+1]),
         .out_ready (chain_ready[n+1]),
         .out_data  (chain_data[n+1])
      );
   end

   assign req_stall = ~front_ready;
   assign out_ld    = ~rsp_valid_ff | ~rsp_stall;
   assign chain_ready[NCELL] = out_ld;

   always_comb begin
      logic dg;
      dg = chain_data[NCELL].degenerate;
      rsp_data_in.m_r0_c0    = to_entry(chain_data[NCELL].lane[0], dg);
      rsp_data_in.m_r0_c1    = to_entry(chain_data[NCELL].lane[1], dg);
      rsp_data_in.m_r0_c2    = to_entry(chain_data[NCELL].lane[2], dg);
      rsp_data_in.m_r1_c0    = to_entry(chain_data[NCELL].lane[3], dg);
      rsp_data_in.m_r1_c1    = to_entry(chain_data[NCELL].lane[4], dg);
      rsp_data_in.m_r1_c2    = to_entry(chain_data[NCELL].lane[5], dg);
      rsp_data_in.m_r2_c0    = to_entry(chain_data[NCELL].lane[6], dg);
      rsp_data_in.m_r2_c1    = to_entry(chain_data[NCELL].lane[7], dg);
      rsp_data_in.m_r2_c2    = to_entry(chain_data[NCELL].lane[8], dg);
      rsp_data_in.degenerate = dg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ld) begin
         rsp_valid_ff <= chain_valid[NCELL];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ld && chain_valid[NCELL]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// testbench for orthonormal_frame_from_two_vectors: random and directed vector pairs,
// exact-rounding frame predictor with an in-order scoreboard
// depends on ofr_pkg and the rtl top level

module tb_top;
   import ofr_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int RANDOM_WORDS   = 700;

   class frame_scoreboard;
      rsp_type pending[$];
      int      errors;

      // largest q with (2q-1)^2 * den <= 4 * num * 2^(2*frac): sqrt rounded half up
      function automatic longint unit_magnitude(logic [159:0] num, logic [159:0] den);
         logic [159:0] rhs;
         logic [159:0] t;
         longint lo;
         longint hi;
         longint mid;
         rhs = num << (2 + 2 * FRAC_BITS);
         lo = 0;
         hi = longint'(1) << FRAC_BITS;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t = 160'(2 * mid - 1);
            if (t * t * den <= rhs) lo = mid;
            else hi = mid - 1;
         end
         return lo;
      endfunction

      function automatic logic [OUT_BITS-1:0] signed_entry(longint q, bit neg);
         return neg ? OUT_BITS'(-q) : OUT_BITS'(q);
      endfunction

      function automatic rsp_type predict_frame(req_type w);
         longint a[3];
         longint b[3];
         longint c[3];
         longint wv;
         longint asq;
         logic [159:0] csq;
         logic [159:0] den1;
         logic [159:0] sq;
         logic [OUT_BITS-1:0] e[9];
         rsp_type r;
         int j;
         int k;
         a[0] = w.axis_a_x; a[1] = w.axis_a_y; a[2] = w.axis_a_z;
         b[0] = w.axis_b_x; b[1] = w.axis_b_y; b[2] = w.axis_b_z;
         c[0] = a[1] * b[2] - a[2] * b[1];
         c[1] = a[2] * b[0] - a[0] * b[2];
         c[2] = a[0] * b[1] - a[1] * b[0];
         asq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
         r = '0;
         if (asq == 0 || (c[0] == 0 && c[1] == 0 && c[2] == 0)) begin
            r.degenerate = 1'b1;
            return r;
         end
         csq = 0;
         for (int i = 0; i < 3; i++) begin
            sq = 160'(c[i] < 0 ? -c[i] : c[i]);
            csq = csq + sq * sq;
         end
         den1 = csq * 160'(asq);
         for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            e[i*3+0] = signed_entry(unit_magnitude(160'(a[i] * a[i]), 160'(asq)), a[i] < 0);
            sq = 160'(c[i] < 0 ? -c[i] : c[i]);
            e[i*3+2] = signed_entry(unit_magnitude(sq * sq, csq), c[i] < 0);
            // secondary column is (a x b) x a, normalized
            wv = c[j] * a[k] - c[k] * a[j];
            sq = 160'(wv < 0 ? -wv : wv);
            e[i*3+1] = signed_entry(unit_magnitude(sq * sq, den1), wv < 0);
         end
         r.m_r0_c0 = e[0]; r.m_r0_c1 = e[1]; r.m_r0_c2 = e[2];
         r.m_r1_c0 = e[3]; r.m_r1_c1 = e[4]; r.m_r1_c2 = e[5];
         r.m_r2_c0 = e[6]; r.m_r2_c1 = e[7]; r.m_r2_c2 = e[8];
         r.degenerate = 1'b0;
         return r;
      endfunction

      function void note_input(req_type w);
         pending.push_back(predict_frame(w));
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("tb: mismatch %s got %0d expected %0d at %0t", what, got, want, $time);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         logic [OUT_BITS-1:0] g[9];
         logic [OUT_BITS-1:0] x[9];
         if (pending.size() == 0) begin
            report_mismatch("unexpected word", 0, 0);
            return;
         end
         want = pending.pop_front();
         g = '{got.m_r0_c0, got.m_r0_c1, got.m_r0_c2, got.m_r1_c0, got.m_r1_c1,
               got.m_r1_c2, got.m_r2_c0, got.m_r2_c1, got.m_r2_c2};
         x = '{want.m_r0_c0, want.m_r0_c1, want.m_r0_c2, want.m_r1_c0, want.m_r1_c1,
               want.m_r1_c2, want.m_r2_c0, want.m_r2_c1, want.m_r2_c2};
         for (int i = 0; i < 9; i++)
            if (g[i] !== x[i])
               report_mismatch($sformatf("m_r%0d_c%0d", i / 3, i % 3),
                               $signed(g[i]), $signed(x[i]));
         if (got.degenerate !== want.degenerate)
            report_mismatch("degenerate", got.degenerate, want.degenerate);
      endtask
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   frame_scoreboard frames = new();
   int cycle_count = 0;
   int idle_cycles = 0;

   orthonormal_frame_from_two_vectors u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stall pattern steps in turn through four characters: none, random, periodic, mostly stalled
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      case ((cycle_count / 256) % 4)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         2: rsp_stall <= ((cycle_count % 16) < 10);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // monitors sample pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) frames.note_input(req_data);
         if (rsp_valid && !rsp_stall) frames.check_result(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else if (req_valid || frames.pending.size() != 0) idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task send_word(req_type w);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   task pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames.pending.size() != 0) @(posedge clock);
   endtask

   function automatic req_type vec_pair(int ax, int ay, int az, int bx, int by, int bz);
      req_type w;
      w.axis_a_x = IN_BITS'(ax); w.axis_a_y = IN_BITS'(ay); w.axis_a_z = IN_BITS'(az);
      w.axis_b_x = IN_BITS'(bx); w.axis_b_y = IN_BITS'(by); w.axis_b_z = IN_BITS'(bz);
      return w;
   endfunction

   function automatic int corner_value();
      case ($urandom_range(0, 4))
         0: return -32768;
         1: return 32767;
         2: return -1;
         3: return 1;
         default: return 0;
      endcase
   endfunction

   function automatic req_type random_word();
      req_type w;
      int ax, ay, az, s;
      w = req_type'({$urandom, $urandom, $urandom});
      case ($urandom_range(0, 9))
         4: w = vec_pair($urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
                         $urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
                         $urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8);
         5: begin
            // parallel or antiparallel pair
            ax = $urandom_range(0, 200) - 100;
            ay = $urandom_range(0, 200) - 100;
            az = $urandom_range(0, 200) - 100;
            s  = $urandom_range(0, 600) - 300;
            w  = vec_pair(ax, ay, az, ax * s, ay * s, az * s);
         end
         6: if ($urandom_range(0, 1)) w = vec_pair(0, 0, 0, w.axis_b_x, w.axis_b_y, w.axis_b_z);
            else w = vec_pair(w.axis_a_x, w.axis_a_y, w.axis_a_z, 0, 0, 0);
         7: w = vec_pair(corner_value(), corner_value(), corner_value(),
                         corner_value(), corner_value(), corner_value());
         default: ;
      endcase
      return w;
   endfunction

   initial begin
      int burst;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(vec_pair(1, 0, 0, 0, 1, 0));
      send_word(vec_pair(0, 0, 1, 1, 0, 0));
      send_word(vec_pair(0, 0, 0, 3, 4, 5));
      send_word(vec_pair(3, 4, 5, 0, 0, 0));
      send_word(vec_pair(0, 0, 0, 0, 0, 0));
      send_word(vec_pair(3, 4, 0, 6, 8, 0));
      send_word(vec_pair(3, 4, 0, -3, -4, 0));
      send_word(vec_pair(32767, 32767, 32767, -32768, 32767, -32768));
      send_word(vec_pair(-32768, -32768, -32768, 32767, -32768, 0));
      send_word(vec_pair(-32768, 0, 0, 0, -32768, 0));
      send_word(vec_pair(32767, -32768, 1, -1, 32767, -32768));
      send_word(vec_pair(1, 1, 1, 1, -1, 0));
      send_word(vec_pair(-1, -1, -1, 1, 1, 1));
      send_word(vec_pair(1, 2, 3, 1, 2, 4));
      send_word(vec_pair(-32768, -32768, -32768, -32768, -32768, -32767));
      pause_until_drained();

      for (int n = 0; n < RANDOM_WORDS; n += burst) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst; i++) send_word(random_word());
         if (n < RANDOM_WORDS / 2 && n + burst >= RANDOM_WORDS / 2) pause_until_drained();
         else if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frames.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

### sim.f
rtl/ofr_pkg.sv
rtl/ofr_front.sv
rtl/ofr_cell.sv
rtl/orthonormal_frame_from_two_vectors.sv
bench/tb_top.sv
